@@ rtl/core/ata_pkg.sv @@
// shared types and constants for the accelerometer tilt angle pipeline
`timescale 1ns / 1ps
`default_nettype none
package ata_pkg;

	// working widths: operands pre-shifted by 20 bits, angle in 2^-24 degree
	localparam int XY_W      = 40;
	localparam int Z_W       = 34;
	localparam int PRE_SHIFT = 20;
	localparam int TBL_BITS  = 24;
	localparam int TBL_LEN   = 24;

	localparam logic signed [Z_W-1:0] DEG90  = 34'sd1509949440;
	localparam logic signed [Z_W-1:0] DEG180 = 34'sd3019898880;

	// atan(2^-i) in 2^-24 degree
	localparam logic [31:0] ATAN_TBL [TBL_LEN] = '{
		32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
		32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
		32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
		32'd234684,    32'd117342,    32'd58671,     32'd29335,
		32'd14668,     32'd7334,      32'd3667,      32'd1833,
		32'd917,       32'd458,       32'd229,       32'd115
	};

	// one lane's vector and angle as it moves down the chain
	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
		logic                   byp;
	} lane_t;

endpackage
`default_nettype wire

@@ rtl/core/ata_prep.sv @@
// front stage of one lane: quadrant fold and axis special cases
`timescale 1ns / 1ps
`default_nettype none
module ata_prep (
	input  wire                  clk,
	input  wire signed [15:0]    num,
	input  wire signed [15:0]    den,
	output ata_pkg::lane_t       lane
);

	logic signed [ata_pkg::XY_W-1:0] a_w;
	logic signed [ata_pkg::XY_W-1:0] b_w;
	ata_pkg::lane_t                  nxt;
	ata_pkg::lane_t                  res_s1;

	always_comb begin
		a_w = $signed({{4{num[15]}}, num, 20'b0});
		b_w = $signed({{4{den[15]}}, den, 20'b0});
		nxt.byp = 1'b0;
		if (num == 16'sd0) begin
			nxt.byp = 1'b1;
			nxt.x   = b_w;
			nxt.y   = a_w;
			nxt.z   = den[15] ? ata_pkg::DEG180 : '0;
		end else if (den == 16'sd0) begin
			nxt.byp = 1'b1;
			nxt.x   = b_w;
			nxt.y   = a_w;
			nxt.z   = num[15] ? -ata_pkg::DEG90 : ata_pkg::DEG90;
		end else if (den[15]) begin
			// left half plane: rotate by 180 degrees first
			nxt.x = -b_w;
			nxt.y = -a_w;
			nxt.z = num[15] ? -ata_pkg::DEG180 : ata_pkg::DEG180;
		end else begin
			nxt.x = b_w;
			nxt.y = a_w;
			nxt.z = '0;
		end
	end

	always_ff @(posedge clk) begin
		res_s1 <= nxt;
	end

	assign lane = res_s1;

endmodule
`default_nettype wire

@@ rtl/core/ata_cell.sv @@
// one vectoring cordic micro-rotation for one lane
`timescale 1ns / 1ps
`default_nettype none
module ata_cell #(
	parameter int IDX = 0
) (
	input  wire                  clk,
	input  ata_pkg::lane_t       lane_in,
	output ata_pkg::lane_t       lane_out
);

	logic signed [ata_pkg::XY_W-1:0] xs;
	logic signed [ata_pkg::XY_W-1:0] ys;
	logic signed [ata_pkg::Z_W-1:0]  atan_v;
	ata_pkg::lane_t                  nxt;
	ata_pkg::lane_t                  res_s1;

	always_comb begin
		xs     = $signed(lane_in.x) >>> IDX;
		ys     = $signed(lane_in.y) >>> IDX;
		atan_v = $signed({2'b00, ata_pkg::ATAN_TBL[IDX]});
		nxt    = lane_in;
		if (!lane_in.byp) begin
			if (!lane_in.y[ata_pkg::XY_W-1]) begin
				nxt.x = lane_in.x + ys;
				nxt.y = lane_in.y - xs;
				nxt.z = lane_in.z + atan_v;
			end else begin
				nxt.x = lane_in.x - ys;
				nxt.y = lane_in.y + xs;
				nxt.z = lane_in.z - atan_v;
			end
		end
	end

	always_ff @(posedge clk) begin
		res_s1 <= nxt;
	end

	assign lane_out = res_s1;

endmodule
`default_nettype wire

@@ rtl/core/ata_round.sv @@
// output stage of one lane: round to the angle grid and clamp
`timescale 1ns / 1ps
`default_nettype none
module ata_round #(
	parameter int ANGLE_FRAC_BITS = 7
) (
	input  wire                  clk,
	input  wire signed [ata_pkg::Z_W-1:0] z,
	output logic signed [15:0]   angle
);

	localparam int SH    = ata_pkg::TBL_BITS - ANGLE_FRAC_BITS;
	localparam int LIM_I = 180 << ANGLE_FRAC_BITS;
	localparam int HI_I  = (LIM_I > 32767) ? 32767 : LIM_I;
	localparam int LO_I  = (LIM_I > 32768) ? -32768 : -LIM_I;
	localparam logic signed [ata_pkg::Z_W:0] HALF = (ata_pkg::Z_W+1)'(1) <<< (SH - 1);
	localparam logic signed [ata_pkg::Z_W:0] HI_V = (ata_pkg::Z_W+1)'(HI_I);
	localparam logic signed [ata_pkg::Z_W:0] LO_V = (ata_pkg::Z_W+1)'(LO_I);

	logic signed [ata_pkg::Z_W:0] sum;
	logic signed [ata_pkg::Z_W:0] r;
	logic signed [ata_pkg::Z_W:0] c;
	logic signed [15:0]           res_s1;

	always_comb begin
		sum = $signed({z[ata_pkg::Z_W-1], z}) + HALF;
		r   = sum >>> SH;
		if (r > HI_V) begin
			c = HI_V;
		end else if (r < LO_V) begin
			c = LO_V;
		end else begin
			c = r;
		end
	end

	always_ff @(posedge clk) begin
		res_s1 <= c[15:0];
	end

	assign angle = res_s1;

endmodule
`default_nettype wire

@@ rtl/core/accel_tilt_angles.sv @@
// top level: three pipelined atan2 lanes giving accelerometer tilt angles
//
//  channel   handshake          payload
//  -------   ----------------   ----------------------------------
//  input     start / busy       accel_x, accel_y, accel_z
//  result    done (strobe)      angle_yz, angle_xz, angle_xy
//
// one item enters per cycle; every cordic cell is a registered stage of its lane
// an item passes the fold stage, the cell chain and the rounding stage, each registered
// busy is always low, the chain never holds an item back
// done is high for exactly one cycle per item, results are not held
// reset clears only the valid chain; payload registers are not reset
`timescale 1ns / 1ps
`default_nettype none
module accel_tilt_angles #(
	parameter int ANGLE_FRAC_BITS = 7,
	parameter int CORDIC_STAGES   = 16
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	input  wire signed [15:0]  accel_x,
	input  wire signed [15:0]  accel_y,
	input  wire signed [15:0]  accel_z,
	output logic               done,
	output logic signed [15:0] angle_yz,
	output logic signed [15:0] angle_xz,
	output logic signed [15:0] angle_xy
);

	localparam int LAT = CORDIC_STAGES + 2;
	localparam int AMAX_I = ((180 << ANGLE_FRAC_BITS) > 32767) ? 32767
		: (180 << ANGLE_FRAC_BITS);
	localparam logic signed [15:0] AMAX = 16'(AMAX_I);

	// lane 0: atan2(y,z), lane 1: atan2(x,z), lane 2: atan2(x,y)
	ata_pkg::lane_t     chain [3][CORDIC_STAGES+1];
	logic signed [15:0] num_l [3];
	logic signed [15:0] den_l [3];
	logic signed [15:0] ang_l [3];
	logic [LAT-1:0]     vld_q;

	assign num_l[0] = accel_y;
	assign den_l[0] = accel_z;
	assign num_l[1] = accel_x;
	assign den_l[1] = accel_z;
	assign num_l[2] = accel_x;
	assign den_l[2] = accel_y;

	for (genvar l = 0; l < 3; l++) begin : g_lane
		// quadrant fold into the right half plane
		ata_prep u_prep (
			.clk  (clk),
			.num  (num_l[l]),
			.den  (den_l[l]),
			.lane (chain[l][0])
		);
		// one cell per micro-rotation, each hands its vector to the next
		for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_cell
			ata_cell #(
				.IDX (s)
			) u_cell (
				.clk      (clk),
				.lane_in  (chain[l][s]),
				.lane_out (chain[l][s+1])
			);
		end
		ata_round #(
			.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
		) u_round (
			.clk   (clk),
			.z     (chain[l][CORDIC_STAGES].z),
			.angle (ang_l[l])
		);
	end

	// valid marks travel alongside the lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start};
		end
	end

	assign busy     = 1'b0;
	assign done     = vld_q[LAT-1];
	assign angle_yz = ang_l[0];
	assign angle_xz = ang_l[1];
	assign angle_xy = ang_l[2];

`ifndef SYNTHESIS
	// an accepted item comes out after the fixed pipeline latency
	a_latency : assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("item did not reach the result port on time");

	// results stay within the half-turn range
	a_range : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (angle_yz <= AMAX && angle_yz >= -AMAX - 16'sd1
			&& angle_xz <= AMAX && angle_xz >= -AMAX - 16'sd1
			&& angle_xy <= AMAX && angle_xy >= -AMAX - 16'sd1))
		else $error("angle outside the half-turn range");

	// zero y with non-negative z gives zero pitch angle
	a_zero_yz : assert property (@(posedge clk) disable iff (!arst_n)
		(start && accel_y == 16'sd0 && !accel_z[15]) |-> ##LAT (angle_yz == 16'sd0))
		else $error("atan2 with zero numerator and non-negative denominator not zero");

	// zero x with non-negative y gives zero heading angle
	a_zero_xy : assert property (@(posedge clk) disable iff (!arst_n)
		(start && accel_x == 16'sd0 && !accel_y[15]) |-> ##LAT (angle_xy == 16'sd0))
		else $error("atan2 with zero numerator and non-negative denominator not zero");
`endif

endmodule
`default_nettype wire
